FILE: src/angle_frame_crc_checker_defines.svh
// ----------------------------------------------------------------------------
// Angle frame CRC checker: assertion macros
// Shared concurrent assertion helpers, clocked on rising edge, reset masked.
// ----------------------------------------------------------------------------
`ifndef ANGLE_FRAME_CRC_CHECKER_DEFINES_SVH
`define ANGLE_FRAME_CRC_CHECKER_DEFINES_SVH

// same-cycle implication
`define AFCC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define AFCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/afcc_pkg.sv
// ----------------------------------------------------------------------------
// afcc_pkg
// Word types, frame states and CRC-8 step for the angle frame checker.
// ----------------------------------------------------------------------------
package afcc_pkg;

    localparam logic [7:0] CRC_POLY = 8'h07;
    localparam logic [7:0] CRC_INIT = 8'h00;
    localparam logic [7:0] CRC_MSB  = 8'h80;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_start;
    } t_in_word;

    typedef struct packed {
        logic [20:0] angle_count;
        logic [2:0]  device_status;
        logic        crc_error;
    } t_out_word;

    // next byte expected; byte 0 is consumed by the start mark itself
    typedef enum logic [5:0] {
        S_B1   = 6'b000001,
        S_B2   = 6'b000010,
        S_B3   = 6'b000100,
        S_B4   = 6'b001000,
        S_B5   = 6'b010000,
        S_IDLE = 6'b100000
    } t_pos;

    // MSB-first CRC-8 over one byte, unrolled
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
                                             input logic [7:0] data);
        logic [7:0] c;
        c = crc_in ^ data;
        for (int k = 0; k < 8; k++) begin
            if ((c & CRC_MSB) != 8'h00) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

FILE: src/afcc_in_reg.sv
// ----------------------------------------------------------------------------
// afcc_in_reg
// Input register: holds one accepted word until the frame stage takes it.
// ----------------------------------------------------------------------------
module afcc_in_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  afcc_pkg::t_in_word i_word,
    output logic              o_vld,
    output afcc_pkg::t_in_word o_word,
    input  logic              i_adv
);

    logic               r_vld;
    afcc_pkg::t_in_word r_word;

    assign o_ready = !r_vld || i_adv;
    assign o_vld   = r_vld;
    assign o_word  = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_word <= i_word;
        end
    end

endmodule

FILE: src/afcc_frame.sv
// ----------------------------------------------------------------------------
// afcc_frame
// Frame tracker, angle/status assembly, CRC and the result register.
// ----------------------------------------------------------------------------
`include "angle_frame_crc_checker_defines.svh"

module afcc_frame (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_check_crc,
    input  logic                i_vld,
    input  afcc_pkg::t_in_word  i_word,
    output logic                o_adv,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output afcc_pkg::t_out_word o_out_word
);

    afcc_pkg::t_pos      r_pos,    n_pos;
    logic [20:0]         r_angle,  n_angle;
    logic [2:0]          r_status, n_status;
    logic [7:0]          r_crc,    n_crc;
    logic                r_out_vld;
    afcc_pkg::t_out_word r_out_word;
    logic                n_emit;
    logic [7:0]          w_byte;

    assign w_byte      = i_word.rx_byte;
    assign o_adv       = i_vld && (!r_out_vld || i_out_ready);
    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out_word;

    always_comb begin
        n_pos    = r_pos;
        n_angle  = r_angle;
        n_status = r_status;
        n_crc    = r_crc;
        n_emit   = 1'b0;
        if (o_adv) begin
            if (i_word.frame_start) begin
                n_crc = afcc_pkg::CRC_INIT;
                n_pos = afcc_pkg::S_B1;
            end else begin
                case (r_pos)
                    afcc_pkg::S_B1: begin
                        n_pos = afcc_pkg::S_B2;
                    end
                    afcc_pkg::S_B2: begin
                        n_angle = {w_byte, 13'd0};
                        n_crc   = afcc_pkg::crc8_byte(afcc_pkg::CRC_INIT, w_byte);
                        n_pos   = afcc_pkg::S_B3;
                    end
                    afcc_pkg::S_B3: begin
                        n_angle = r_angle | {8'd0, w_byte, 5'd0};
                        n_crc   = afcc_pkg::crc8_byte(r_crc, w_byte);
                        n_pos   = afcc_pkg::S_B4;
                    end
                    afcc_pkg::S_B4: begin
                        n_angle  = r_angle | {16'd0, w_byte[7:3]};
                        n_status = w_byte[2:0];
                        n_crc    = afcc_pkg::crc8_byte(r_crc, w_byte);
                        n_pos    = afcc_pkg::S_B5;
                    end
                    afcc_pkg::S_B5: begin
                        n_emit = 1'b1;
                        n_pos  = afcc_pkg::S_IDLE;
                    end
                    default: begin
                        n_pos = afcc_pkg::S_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= afcc_pkg::S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_pos <= n_pos;
            if (n_emit) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_angle  <= n_angle;
        r_status <= n_status;
        r_crc    <= n_crc;
        if (n_emit) begin
            r_out_word.angle_count   <= r_angle;
            r_out_word.device_status <= r_status;
            r_out_word.crc_error     <= i_check_crc && (w_byte != r_crc);
        end
    end

    `AFCC_ASSERT_NEXT(a_start_to_b1, i_clk, i_rst_n,
        o_adv && i_word.frame_start, r_pos == afcc_pkg::S_B1,
        "start mark did not reset frame position")
    `AFCC_ASSERT_NEXT(a_b5_emits, i_clk, i_rst_n,
        o_adv && !i_word.frame_start && r_pos == afcc_pkg::S_B5,
        r_out_vld && r_pos == afcc_pkg::S_IDLE,
        "last byte did not produce a result")
    `AFCC_ASSERT_NOW(a_no_err_unchecked, i_clk, i_rst_n,
        r_out_vld && !i_check_crc, !r_out_word.crc_error,
        "crc error flagged with checking disabled")
    `AFCC_ASSERT_NOW(a_pos_onehot, i_clk, i_rst_n,
        1'b1, $onehot(r_pos),
        "frame position not one-hot")

endmodule

FILE: src/angle_frame_crc_checker.sv
// ----------------------------------------------------------------------------
// angle_frame_crc_checker
// Six-byte encoder angle frame parser with CRC-8 (poly 0x07) check.
// ----------------------------------------------------------------------------
// Input channel carries one received byte per word plus a start mark that
// opens a frame. Bytes 0-1 are skipped, bytes 2-4 give the 21-bit angle and
// 3 status bits, byte 5 is the received CRC. After byte 5 one output word
// carries angle, status and crc_error (set only when check_crc is 1).
// Throughput: one input word per cycle while the receiver takes results; a
// byte passes the input register, then the frame logic (one unrolled CRC
// step) into the output register, where out_valid rises once the frame logic
// has taken the last byte of the frame.
// A start mark mid-frame restarts the frame; bytes outside a frame are dropped.
// If the receiver stalls, the output word holds, the input register fills
// and in_ready drops once both are occupied; nothing is lost.
// Reset (synchronous, active low) empties both registers, sets the tracker
// idle awaiting a start mark and clears check_crc. check_crc is written via
// cfg_we/cfg_wdata at any edge, intended only while the block is idle.
// ----------------------------------------------------------------------------
module angle_frame_crc_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  afcc_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output afcc_pkg::t_out_word o_out_word,
    input  logic                i_cfg_we,
    input  logic                i_cfg_wdata
);

    logic               r_check_crc;
    logic               w_vld;
    logic               w_adv;
    afcc_pkg::t_in_word w_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_check_crc <= 1'b0;
        end else if (i_cfg_we) begin
            r_check_crc <= i_cfg_wdata;
        end
    end

    afcc_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_word  (i_in_word),
        .o_vld   (w_vld),
        .o_word  (w_word),
        .i_adv   (w_adv)
    );

    afcc_frame u_frame (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_check_crc (r_check_crc),
        .i_vld       (w_vld),
        .i_word      (w_word),
        .o_adv       (w_adv),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

endmodule

FILE: dv/tb_angle_frame_crc_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_angle_frame_crc_checker
// Drives six-byte angle frames through the checker and compares each output
// word field by field against a frame tracker. The stimulus covers clean
// frames, bad CRC bytes, frames cut short by a new start mark and stray bytes
// outside a frame, with check_crc both off and on and random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_angle_frame_crc_checker;

    // Tracks the frame position, angle, status and running CRC of the
    // checker and queues the output word each completed frame should give.
    class frame_tracker;
        afcc_pkg::t_out_word frames_due[$];
        afcc_pkg::t_pos      pos;
        logic [20:0]         angle;
        logic [2:0]          status;
        logic [7:0]          crc;
        bit                  check_crc;
        int                  errors;

        function new();
            pos       = afcc_pkg::S_IDLE;
            angle     = '0;
            status    = '0;
            crc       = 8'h00;
            check_crc = 1'b0;
            errors    = 0;
        endfunction

        // bit-serial CRC-8, poly 0x07, MSB first
        function logic [7:0] crc_step(input logic [7:0] c, input logic [7:0] d);
            logic fb;
            for (int i = 7; i >= 0; i--) begin
                fb = c[7] ^ d[i];
                c  = {c[6:0], 1'b0};
                if (fb) begin
                    c = c ^ 8'h07;
                end
            end
            return c;
        endfunction

        function void take_byte(input afcc_pkg::t_in_word w);
            afcc_pkg::t_out_word res;
            if (w.frame_start) begin
                crc = 8'h00;
                pos = afcc_pkg::S_B1;
                return;
            end
            case (pos)
                afcc_pkg::S_B1: begin
                    pos = afcc_pkg::S_B2;
                end
                afcc_pkg::S_B2: begin
                    angle = {w.rx_byte, 13'd0};
                    crc   = crc_step(8'h00, w.rx_byte);
                    pos   = afcc_pkg::S_B3;
                end
                afcc_pkg::S_B3: begin
                    angle[12:5] = w.rx_byte;
                    crc         = crc_step(crc, w.rx_byte);
                    pos         = afcc_pkg::S_B4;
                end
                afcc_pkg::S_B4: begin
                    angle[4:0] = w.rx_byte[7:3];
                    status     = w.rx_byte[2:0];
                    crc        = crc_step(crc, w.rx_byte);
                    pos        = afcc_pkg::S_B5;
                end
                afcc_pkg::S_B5: begin
                    res.angle_count   = angle;
                    res.device_status = status;
                    res.crc_error     = check_crc && (w.rx_byte != crc);
                    frames_due.push_back(res);
                    pos = afcc_pkg::S_IDLE;
                end
                default: begin
                    pos = afcc_pkg::S_IDLE;
                end
            endcase
        endfunction

        function void compare_frame(input afcc_pkg::t_out_word got);
            afcc_pkg::t_out_word want;
            if (frames_due.size() == 0) begin
                $display("%0t: unexpected word angle=%h status=%h crc_error=%b",
                         $time, got.angle_count, got.device_status, got.crc_error);
                errors++;
                return;
            end
            want = frames_due.pop_front();
            if (got.angle_count !== want.angle_count) begin
                $display("%0t: angle_count expected %h actual %h",
                         $time, want.angle_count, got.angle_count);
                errors++;
            end
            if (got.device_status !== want.device_status) begin
                $display("%0t: device_status expected %h actual %h",
                         $time, want.device_status, got.device_status);
                errors++;
            end
            if (got.crc_error !== want.crc_error) begin
                $display("%0t: crc_error expected %b actual %b",
                         $time, want.crc_error, got.crc_error);
                errors++;
            end
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    afcc_pkg::t_in_word  i_in_word;
    logic                o_out_valid;
    logic                i_out_ready;
    afcc_pkg::t_out_word o_out_word;
    logic                i_cfg_we;
    logic                i_cfg_wdata;

    frame_tracker sb = new();
    bit           quiet = 1'b0;
    int           words_sent = 0;

    angle_frame_crc_checker dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // receiver: check accepted words, stall at random
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.compare_frame(o_out_word);
        end
        i_out_ready <= quiet || ($urandom_range(99) >= 14);
    end

    task automatic send_word(input afcc_pkg::t_in_word w);
        while (!quiet && $urandom_range(99) < 14) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (!o_in_ready);
        sb.take_byte(w);
    endtask

    // sends the first nbytes of a frame; flip corrupts the CRC byte
    task automatic send_frame(input logic [20:0] ang, input logic [2:0] st,
                              input logic [7:0] flip, input int nbytes);
        logic [7:0]         bytes [6];
        logic [7:0]         c;
        afcc_pkg::t_in_word w;
        bytes[0] = 8'($urandom);
        bytes[1] = 8'($urandom);
        bytes[2] = ang[20:13];
        bytes[3] = ang[12:5];
        bytes[4] = {ang[4:0], st};
        c = 8'h00;
        for (int i = 2; i < 5; i++) begin
            c = sb.crc_step(c, bytes[i]);
        end
        bytes[5] = c ^ flip;
        for (int i = 0; i < nbytes; i++) begin
            w.rx_byte     = bytes[i];
            w.frame_start = (i == 0);
            send_word(w);
            words_sent++;
        end
    endtask

    // stop sending and let every pending word come out
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.frames_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_check_crc(input bit v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we      <= 1'b0;
        sb.check_crc = v;
    endtask

    initial begin : stimulus
        afcc_pkg::t_in_word w;
        logic [20:0]        ang;
        logic [2:0]         st;
        int                 kind;
        int                 goal;

        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_word   <= '0;
        i_out_ready <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // stray byte before any frame is dropped
        w.rx_byte     = 8'hFF;
        w.frame_start = 1'b0;
        send_word(w);
        // check_crc still at its reset value: bad CRC gives no flag
        send_frame(21'h1FFFFF, 3'd7, 8'hA5, 6);
        drain();
        write_check_crc(1'b1);
        // cut-off frame, then a clean all-zero frame
        send_frame(21'h000000, 3'd0, 8'h00, 4);
        send_frame(21'h000000, 3'd0, 8'h00, 6);
        send_frame(21'h1FFFFF, 3'd7, 8'hFF, 6);

        for (int ph = 0; ph < 4; ph++) begin
            drain();
            write_check_crc(ph[0]);
            goal  = words_sent + 270;
            quiet = (ph == 2);
            while (words_sent < goal) begin
                kind = int'($urandom_range(99));
                ang  = 21'($urandom);
                st   = 3'($urandom);
                if (kind < 70) begin
                    send_frame(ang, st, 8'h00, 6);
                end else if (kind < 80) begin
                    send_frame(ang, st, 8'($urandom_range(255, 1)), 6);
                end else if (kind < 90) begin
                    send_frame(ang, st, 8'h00, int'($urandom_range(5, 1)));
                end else begin
                    repeat ($urandom_range(3, 1)) begin
                        w.rx_byte     = 8'($urandom);
                        w.frame_start = 1'b0;
                        send_word(w);
                    end
                end
                if (quiet && words_sent >= goal - 120) begin
                    quiet = 1'b0;
                end
            end
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #400000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
